>>> src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge while reset is released.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/mkdb_pkg.sv
// Package for the multi-key debouncer: payload types, codes and defaults.
package mkdb_pkg;

  localparam int NUM_KEYS_DEF = 4;

  localparam int MODE_W   = 2;
  localparam int LEVELS_W = 4;
  localparam int QUERY_W  = 3;
  localparam int EVENT_W  = 3;
  localparam int HOLD_W   = 16;
  localparam int MASK_W   = 4;
  localparam int DEB_W    = 8;

  localparam int MAX_QUERY = (1 << QUERY_W) - 1;

  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TAKE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT = 1'd1;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RST   = 8'd20;
  localparam logic [HOLD_W-1:0] HOLD_LIMIT_RST = 16'd60000;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [LEVELS_W-1:0] raw_levels;
    logic [QUERY_W-1:0]  query_key;
  } in_item_t;

  typedef struct packed {
    logic [EVENT_W-1:0] event_key;
    logic [HOLD_W-1:0]  held_ms;
    logic [MASK_W-1:0]  pressed_mask;
  } out_item_t;

  // Per-key status handed from a lane to the merge stage.
  typedef struct packed {
    logic              pressed;      // current confirmed state
    logic              pressed_nxt;  // confirmed state after this item
    logic              pending;
    logic [HOLD_W-1:0] hold_time;
  } lane_stat_t;

endpackage

>>> src/multi_key_debounce_hold_timer_top.sv
// Multi-key debouncer top: config registers, key lanes, merge and output skid.
//
// Input channel in_valid/in_stall/in_data: mode 0 is a tick carrying the raw
// active-low key levels, mode 1 takes the lowest pending press event, mode 2
// queries the hold time of key 1..NUM_KEYS. Every item yields one result on
// out_valid/out_stall/out_data with the event key, hold time and the mask of
// confirmed pressed keys after the item.
// Each result is registered; one item per cycle while in_stall is low, and
// all key lanes update in the accept cycle.
// If the receiver stalls, one more result is parked in a skid register and
// in_stall then rises until the output drains; in_stall is a register.
// cfg_we/cfg_addr/cfg_wdata write debounce_ticks (index 0) and hold_limit
// (index 1); write them only while the block is idle.
// Synchronous reset (rst_n low) releases all keys, clears counts, hold times
// and pending events, empties the output and restores debounce 20, limit 60000.
`include "assert_macros.svh"

module multi_key_debounce_hold_timer_top
  import mkdb_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int LVL_W = (NUM_KEYS < LEVELS_W) ? LEVELS_W : NUM_KEYS;

  logic [DEB_W-1:0]  debounce_r, debounce_nxt;
  logic [HOLD_W-1:0] hold_limit_r, hold_limit_nxt;

  logic                in_acc, tick, take;
  logic [LVL_W-1:0]    lvl_pad;
  lane_stat_t          lanes [NUM_KEYS];
  logic [NUM_KEYS-1:0] take_sel;
  logic [NUM_KEYS-1:0] pending_vec;
  logic [NUM_KEYS-1:0] pressed_vec;
  out_item_t           result;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      skid_full_r, skid_full_nxt;
  out_item_t skid_data_r, skid_data_nxt;

  // configuration
  always_comb begin
    debounce_nxt   = debounce_r;
    hold_limit_nxt = hold_limit_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_DEBOUNCE:   debounce_nxt   = cfg_wdata[DEB_W-1:0];
        REG_HOLD_LIMIT: hold_limit_nxt = cfg_wdata[HOLD_W-1:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      hold_limit_r <= HOLD_LIMIT_RST;
    end else begin
      debounce_r   <= debounce_nxt;
      hold_limit_r <= hold_limit_nxt;
    end
  end

  assign in_stall = skid_full_r;
  assign in_acc   = in_valid && !skid_full_r;
  assign tick     = in_acc && in_data.mode == MODE_TICK;
  assign take     = in_acc && in_data.mode == MODE_TAKE;

  // keys past the level field read as pressed (0)
  assign lvl_pad = LVL_W'(in_data.raw_levels);

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    mkdb_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .tick       (tick),
      .level      (lvl_pad[k]),
      .take       (take && take_sel[k]),
      .debounce   (debounce_r),
      .hold_limit (hold_limit_r),
      .stat       (lanes[k])
    );
    assign pending_vec[k] = lanes[k].pending;
    assign pressed_vec[k] = lanes[k].pressed;
  end

  mkdb_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .item     (in_data),
    .lanes    (lanes),
    .take_sel (take_sel),
    .result   (result)
  );

  // output register plus one skid entry
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    skid_full_nxt = skid_full_r;
    skid_data_nxt = skid_data_r;
    if (!out_valid_r || !out_stall) begin
      if (skid_full_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = skid_data_r;
        skid_full_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_acc;
        out_data_nxt  = result;
      end
    end else if (in_acc) begin
      skid_full_nxt = 1'b1;
      skid_data_nxt = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_RST(a_skid_behind_out, clk, rst_n, skid_full_r |-> out_valid_r, "skid full with empty output")
  `ASSERT_RST(a_take_clears_one, clk, rst_n, (take && pending_vec != '0) |=> ($countones(pending_vec) == $countones($past(pending_vec)) - 1), "take did not clear exactly one event")
  `ASSERT_RST(a_pressed_only_on_tick, clk, rst_n, !tick |=> $stable(pressed_vec), "pressed state changed without a tick")
  `ASSERT_RST(a_one_field_active, clk, rst_n, (out_valid_r && out_data_r.event_key != '0) |-> (out_data_r.held_ms == '0), "event and hold time both nonzero")

endmodule

>>> src/mkdb_lane.sv
// One key lane: debounce counter, confirmed state, hold timer, pending event.
module mkdb_lane
  import mkdb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick,
  input  logic              level,
  input  logic              take,
  input  logic [DEB_W-1:0]  debounce,
  input  logic [HOLD_W-1:0] hold_limit,
  output lane_stat_t        stat
);

  logic              last_level_r, last_level_nxt;
  logic [DEB_W-1:0]  count_r, count_nxt;
  logic              pressed_r, pressed_nxt;
  logic [HOLD_W-1:0] hold_r, hold_nxt;
  logic              pending_r, pending_nxt;
  logic [DEB_W-1:0]  count_inc;

  assign count_inc = count_r + 1'b1;

  always_comb begin
    last_level_nxt = last_level_r;
    count_nxt      = count_r;
    pressed_nxt    = pressed_r;
    hold_nxt       = hold_r;
    pending_nxt    = pending_r;
    if (tick) begin
      if (level != last_level_r) begin
        last_level_nxt = level;
        count_nxt      = '0;
      end else if (count_r < debounce) begin
        count_nxt = count_inc;
        if (count_inc == debounce) begin
          if (!level && !pressed_r) begin
            pressed_nxt = 1'b1;
            hold_nxt    = '0;
            pending_nxt = 1'b1;
          end else if (level && pressed_r) begin
            pressed_nxt = 1'b0;
          end
        end
      end
      // the confirming tick already counts
      if (pressed_nxt && hold_nxt < hold_limit) begin
        hold_nxt = hold_nxt + 1'b1;
      end
    end
    if (take) begin
      pending_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= 1'b1;
      count_r      <= '0;
      pressed_r    <= 1'b0;
      hold_r       <= '0;
      pending_r    <= 1'b0;
    end else begin
      last_level_r <= last_level_nxt;
      count_r      <= count_nxt;
      pressed_r    <= pressed_nxt;
      hold_r       <= hold_nxt;
      pending_r    <= pending_nxt;
    end
  end

  assign stat.pressed     = pressed_r;
  assign stat.pressed_nxt = pressed_nxt;
  assign stat.pending     = pending_r;
  assign stat.hold_time   = hold_r;

endmodule

>>> src/mkdb_merge.sv
// Merge stage: picks the lowest pending event, muxes the queried hold time.
module mkdb_merge
  import mkdb_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  in_item_t           item,
  input  lane_stat_t         lanes [NUM_KEYS],
  output logic [NUM_KEYS-1:0] take_sel,
  output out_item_t          result
);

  localparam int PAD_W = (NUM_KEYS < MASK_W) ? MASK_W : NUM_KEYS;

  logic [NUM_KEYS-1:0] pressed_nxt;
  logic [PAD_W-1:0]    pressed_pad;
  logic [EVENT_W-1:0]  ev_key;
  logic [HOLD_W-1:0]   held;

  always_comb begin
    take_sel = '0;
    ev_key   = '0;
    // scan downward so the lowest pending key wins
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (lanes[k].pending) begin
        take_sel    = '0;
        take_sel[k] = 1'b1;
        ev_key      = EVENT_W'(k + 1);
      end
    end
  end

  always_comb begin
    held = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if ((k + 1) <= MAX_QUERY && item.query_key == QUERY_W'(k + 1) && lanes[k].pressed) begin
        held = lanes[k].hold_time;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      pressed_nxt[k] = lanes[k].pressed_nxt;
    end
  end

  assign pressed_pad = PAD_W'(pressed_nxt);

  always_comb begin
    result.pressed_mask = pressed_pad[MASK_W-1:0];
    result.event_key    = '0;
    result.held_ms      = '0;
    case (item.mode)
      MODE_TAKE:  result.event_key = ev_key;
      MODE_QUERY: result.held_ms   = held;
      default:    ;
    endcase
  end

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the four-key debouncer with press events and hold timers.
`timescale 1ns / 100ps

module tb_top;
  import mkdb_pkg::*;

  localparam int KEYS = NUM_KEYS_DEF;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  bit quiet = 1'b0;         // no idling on either side
  bit hold_off_req = 1'b0;  // asks the receiver for one long stall

  // per-key pin stimulus: level the key is heading to, and bounce left
  logic [KEYS-1:0] pin_target = '1;
  int              bounce_left [KEYS];

  multi_key_debounce_hold_timer_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  class debounce_scoreboard;
    logic [DEB_W-1:0]  deb_limit;
    logic [HOLD_W-1:0] hold_cap;
    logic [KEYS-1:0]   pin_level;
    logic [DEB_W-1:0]  stable_cnt [KEYS];
    logic [KEYS-1:0]   key_down;
    logic [HOLD_W-1:0] hold_cnt [KEYS];
    logic [KEYS-1:0]   press_pending;
    out_item_t         expected_reports [$];
    int                errors;

    function new();
      deb_limit     = DEBOUNCE_RST;
      hold_cap      = HOLD_LIMIT_RST;
      pin_level     = '1;
      key_down      = '0;
      press_pending = '0;
      errors        = 0;
      foreach (stable_cnt[k]) begin
        stable_cnt[k] = '0;
        hold_cnt[k]   = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_DEBOUNCE) deb_limit = data[DEB_W-1:0];
      else hold_cap = data[HOLD_W-1:0];
    endfunction

    function void tick_key(int k, logic lvl);
      if (lvl != pin_level[k]) begin
        pin_level[k]  = lvl;
        stable_cnt[k] = '0;
      end else if (stable_cnt[k] < deb_limit) begin
        stable_cnt[k] = stable_cnt[k] + 1'b1;
        if (stable_cnt[k] == deb_limit) begin
          if (!lvl && !key_down[k]) begin
            key_down[k]      = 1'b1;
            hold_cnt[k]      = '0;
            press_pending[k] = 1'b1;
          end else if (lvl && key_down[k]) begin
            key_down[k] = 1'b0;
          end
        end
      end
      // the confirming tick already counts
      if (key_down[k] && hold_cnt[k] < hold_cap) hold_cnt[k] = hold_cnt[k] + 1'b1;
    endfunction

    function void accept_item(in_item_t it);
      out_item_t rep;
      int k;
      rep = '0;
      case (it.mode)
        MODE_TICK: begin
          for (k = 0; k < KEYS; k++) tick_key(k, it.raw_levels[k]);
        end
        MODE_TAKE: begin
          for (k = 0; k < KEYS && rep.event_key == 0; k++) begin
            if (press_pending[k]) begin
              press_pending[k] = 1'b0;
              rep.event_key    = EVENT_W'(k + 1);
            end
          end
        end
        MODE_QUERY: begin
          if (it.query_key >= 1 && it.query_key <= KEYS && key_down[it.query_key - 1])
            rep.held_ms = hold_cnt[it.query_key - 1];
        end
        default: ;
      endcase
      rep.pressed_mask = key_down;
      expected_reports.push_back(rep);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result: expected none, got ev %0d held %0d mask %h",
                 $time, got.event_key, got.held_ms, got.pressed_mask);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      compare_field("event_key", want.event_key, got.event_key);
      compare_field("held_ms", want.held_ms, got.held_ms);
      compare_field("pressed_mask", want.pressed_mask, got.pressed_mask);
    endfunction

    function int outstanding();
      return expected_reports.size();
    endfunction
  endclass

  debounce_scoreboard sb;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.accept_item(in_data);
      if (out_valid && !out_stall) sb.check_report(out_data);
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 20) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_item_t mk(logic [MODE_W-1:0] m, logic [LEVELS_W-1:0] lv,
                                  logic [QUERY_W-1:0] q);
    in_item_t it;
    it.mode       = m;
    it.raw_levels = lv;
    it.query_key  = q;
    return it;
  endfunction

  // Ticks follow a slowly changing target per key with bounce after each
  // change and occasional single-tick glitches.
  function automatic in_item_t rand_item(int tick_pct, int flip_pm, int noise_pm);
    in_item_t it;
    int r;
    int k;
    it.mode       = MODE_TICK;
    it.raw_levels = LEVELS_W'($urandom_range(0, 15));
    it.query_key  = QUERY_W'($urandom_range(0, MAX_QUERY));
    r = $urandom_range(0, 99);
    if (r < tick_pct) begin
      for (k = 0; k < KEYS; k++) begin
        if ($urandom_range(0, 999) < flip_pm) begin
          pin_target[k]  = ~pin_target[k];
          bounce_left[k] = $urandom_range(0, 4);
        end
        if (bounce_left[k] > 0) begin
          bounce_left[k]--;
          it.raw_levels[k] = 1'($urandom_range(0, 1));
        end else if ($urandom_range(0, 999) < noise_pm) begin
          it.raw_levels[k] = ~pin_target[k];
        end else begin
          it.raw_levels[k] = pin_target[k];
        end
      end
    end else begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        it.mode = MODE_TAKE;
      end else if (r < 85) begin
        it.mode = MODE_QUERY;
        if ($urandom_range(0, 4) != 0) it.query_key = QUERY_W'($urandom_range(1, KEYS));
      end else begin
        it.mode = MODE_UNUSED;
      end
    end
    return it;
  endfunction

  task automatic send(in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (!quiet && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(logic [DEB_W-1:0] deb, logic [HOLD_W-1:0] cap);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_DEBOUNCE;
    cfg_wdata <= CFG_DATA_W'(deb);
    sb.write_reg(REG_DEBOUNCE, CFG_DATA_W'(deb));
    @(posedge clk);
    cfg_addr  <= REG_HOLD_LIMIT;
    cfg_wdata <= cap;
    sb.write_reg(REG_HOLD_LIMIT, cap);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(int deb, int cap, int items, int tick_pct, int flip_pm,
                           int noise_pm);
    drain();
    write_regs(DEB_W'(deb), HOLD_W'(cap));
    repeat (items) send(rand_item(tick_pct, flip_pm, noise_pm));
  endtask

  initial begin
    sb = new();
    foreach (bounce_left[k]) bounce_left[k] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: unused mode, empty take, off-range and released queries
    send(mk(MODE_UNUSED, 4'hA, 3'd5));
    send(mk(MODE_TAKE, 4'h0, 3'd0));
    send(mk(MODE_QUERY, 4'hF, 3'd0));
    send(mk(MODE_QUERY, 4'h0, 3'd7));
    send(mk(MODE_QUERY, 4'h5, 3'd5));
    send(mk(MODE_QUERY, 4'h0, 3'd1));
    send(mk(MODE_TICK, 4'h0, 3'd0));
    send(mk(MODE_TICK, 4'hF, 3'd0));

    // fastest debounce, tiny hold limit: press all, saturate, take all events
    drain();
    write_regs(8'd1, 16'd3);
    repeat (5) send(mk(MODE_TICK, 4'h0, 3'd0));
    for (int q = 1; q <= KEYS; q++) send(mk(MODE_QUERY, 4'hF, QUERY_W'(q)));
    repeat (KEYS + 1) send(mk(MODE_TAKE, 4'hF, 3'd7));
    send(mk(MODE_TICK, 4'hF, 3'd0));
    send(mk(MODE_TICK, 4'hF, 3'd0));
    send(mk(MODE_QUERY, 4'h0, 3'd1));
    send(mk(MODE_TICK, 4'h5, 3'd0));

    run_phase(2, 65535, 100, 60, 80, 30);
    // long stable stretches so counts climb high under the widest debounce
    run_phase(255, 60000, 350, 92, 2, 0);
    // lower both limits under the counts and hold times reached above
    run_phase(3, 5, 100, 60, 60, 40);
    quiet = 1'b1;
    run_phase(0, 0, 60, 70, 50, 50);
    quiet = 1'b0;
    // long receiver hold-off while items keep coming
    drain();
    write_regs(8'd1, 16'd1);
    hold_off_req = 1'b1;
    repeat (100) send(rand_item(60, 100, 50));
    run_phase(4, 200, 100, 65, 60, 30);
    quiet = 1'b1;
    run_phase(5, 1000, 100, 65, 60, 30);
    drain();

    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("[multi_key_debounce_hold_timer_top] OK");
    else
      $display("[multi_key_debounce_hold_timer_top] ERROR");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("[multi_key_debounce_hold_timer_top] ERROR");
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/mkdb_pkg.sv
src/mkdb_lane.sv
src/mkdb_merge.sv
src/multi_key_debounce_hold_timer_top.sv
tb/tb_top.sv
